// ===== rtl/core/bqld_pkg.sv =====
// Package for the 2D biquad lowpass decimator core.
// Holds the shared widths, register indexes and the structs passed between
// the front end, the queue and the filter engine. No dependencies.
package bqld_pkg;

  localparam int MaxWidth     = 1024;
  localparam int ColAw        = $clog2(MaxWidth);
  localparam int CoefW        = 18;
  localparam int FracBits     = 16;
  localparam int HistW        = 24;
  localparam int PixW         = 16;
  localparam int AccW         = 48;
  localparam int ProdW        = CoefW + HistW;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 18;
  localparam int DecimW       = 5;
  localparam int LineW        = 11;
  localparam int RamW         = 4 * HistW;

  localparam logic [CfgIdxW-1:0] CFG_B0    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_B1    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_B2    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_A1    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_A2    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DECIM = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH = 3'd6;

  typedef struct packed {
    logic signed [CoefW-1:0] b0;
    logic signed [CoefW-1:0] b1;
    logic signed [CoefW-1:0] b2;
    logic signed [CoefW-1:0] a1;
    logic signed [CoefW-1:0] a2;
  } coefs_t;

  // One classified pixel, queued between front end and engine.
  typedef struct packed {
    logic signed [PixW-1:0] pix;
    logic [ColAw-1:0]       col;
    logic [9:0]             row;
    logic                   row_en;
    logic                   col_en;
    logic                   colf_en;
    logic                   emit;
    logic                   last;
  } item_t;

  typedef struct packed {
    logic clr_busy;
  } back_stat_t;

endpackage

// ===== rtl/core/bqld_in_if.sv =====
// Input pixel channel: valid/ready handshake with the pixel request payload.
// Depends on nothing.
interface bqld_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pixel_in;
  logic               frame_start;

  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

// ===== rtl/core/bqld_out_if.sv =====
// Output pixel channel: valid/ready handshake with the result payload.
// Depends on nothing.
interface bqld_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pixel_out;
  logic [9:0]         out_col;
  logic [9:0]         out_row;
  logic               row_last;

  modport source (output valid, output pixel_out, output out_col, output out_row,
                  output row_last, input ready);
  modport sink   (input valid, input pixel_out, input out_col, input out_row,
                  input row_last, output ready);
endinterface

// ===== rtl/core/bqld_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bqld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/bqld_front.sv =====
// Front end: accepts pixels, tracks position and decimation phase, and
// classifies each pixel for the engine. Depends on bqld_pkg, bqld_in_if.
module bqld_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bqld_in_if.sink                        in_i,
  input  logic [bqld_pkg::DecimW-1:0]    decim_i,
  input  logic [bqld_pkg::LineW-1:0]     width_i,
  input  logic                           recalc_i,
  input  bqld_pkg::back_stat_t           stat_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output bqld_pkg::item_t                item_o
);
  import bqld_pkg::*;

  logic [4:0]  d_cl;
  logic [10:0] w_cl;
  logic [9:0]  x_q, x_d, y_q, y_d, c_q, c_d, yd_q, yd_d;
  logic [3:0]  xm_q, xm_d, ym_q, ym_d;
  logic [9:0]  x_cur, y_cur, c_cur, yd_cur;
  logic [3:0]  xm_cur, ym_cur;
  logic        col_en;
  logic [11:0] x_ext;

  // serial divider that rebuilds the phase counters after a new factor
  logic        div_busy_q;
  logic [3:0]  cnt_q;
  logic [9:0]  xs_q, ys_q, xquo_q, yquo_q;
  logic [4:0]  xr_q, yr_q;
  logic [5:0]  xt, yt;
  logic [4:0]  xr_n, yr_n;
  logic        xb, yb;

  always_comb begin
    if (decim_i == '0) d_cl = 5'd1;
    else if (decim_i > 5'd16) d_cl = 5'd16;
    else d_cl = decim_i;
    if (width_i == '0) w_cl = 11'd1;
    else if (width_i > 11'(MaxWidth)) w_cl = 11'(MaxWidth);
    else w_cl = width_i;
  end

  assign in_i.ready = !div_busy_q && !stat_i.clr_busy && !q_full_i;
  assign push_o     = in_i.valid && in_i.ready;

  always_comb begin
    if (in_i.frame_start) begin
      x_cur = '0; y_cur = '0; c_cur = '0; yd_cur = '0; xm_cur = '0; ym_cur = '0;
    end else begin
      x_cur = x_q; y_cur = y_q; c_cur = c_q; yd_cur = yd_q; xm_cur = xm_q; ym_cur = ym_q;
    end
    x_ext  = {2'b0, x_cur};
    col_en = (xm_cur == '0) && (x_ext + {7'b0, d_cl} <= {1'b0, w_cl});

    item_o.pix     = in_i.pixel_in;
    item_o.col     = c_cur;
    item_o.row     = yd_cur;
    item_o.row_en  = x_cur >= 10'd2;
    item_o.col_en  = col_en;
    item_o.colf_en = y_cur >= 10'd2;
    item_o.emit    = col_en && (ym_cur == '0);
    item_o.last    = col_en && (x_ext + {6'b0, d_cl, 1'b0} > {1'b0, w_cl});

    if ({1'b0, x_cur} + 11'd1 >= w_cl) begin
      x_d  = '0;
      xm_d = '0;
      c_d  = '0;
      y_d  = y_cur + 10'd1;
      if (y_cur == 10'd1023 || {1'b0, ym_cur} + 5'd1 == d_cl) begin
        ym_d = '0;
        yd_d = (y_cur == 10'd1023) ? '0 : yd_cur + 10'd1;
      end else begin
        ym_d = ym_cur + 4'd1;
        yd_d = yd_cur;
      end
    end else begin
      x_d  = x_cur + 10'd1;
      y_d  = y_cur;
      ym_d = ym_cur;
      yd_d = yd_cur;
      if ({1'b0, xm_cur} + 5'd1 == d_cl) begin
        xm_d = '0;
        c_d  = c_cur + 10'd1;
      end else begin
        xm_d = xm_cur + 4'd1;
        c_d  = c_cur;
      end
    end
  end

  always_comb begin
    xt   = {xr_q, xs_q[9]};
    yt   = {yr_q, ys_q[9]};
    xb   = xt >= {1'b0, d_cl};
    yb   = yt >= {1'b0, d_cl};
    xr_n = xb ? 5'(xt - {1'b0, d_cl}) : xt[4:0];
    yr_n = yb ? 5'(yt - {1'b0, d_cl}) : yt[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0; y_q <= '0; c_q <= '0; yd_q <= '0; xm_q <= '0; ym_q <= '0;
      div_busy_q <= 1'b0;
      cnt_q <= '0;
      xs_q <= '0; ys_q <= '0; xquo_q <= '0; yquo_q <= '0; xr_q <= '0; yr_q <= '0;
    end else if (recalc_i) begin
      div_busy_q <= 1'b1;
      cnt_q <= '0;
      xs_q <= x_q; ys_q <= y_q;
      xr_q <= '0; yr_q <= '0; xquo_q <= '0; yquo_q <= '0;
    end else if (div_busy_q) begin
      xs_q   <= {xs_q[8:0], 1'b0};
      ys_q   <= {ys_q[8:0], 1'b0};
      xr_q   <= xr_n;
      yr_q   <= yr_n;
      xquo_q <= {xquo_q[8:0], xb};
      yquo_q <= {yquo_q[8:0], yb};
      cnt_q  <= cnt_q + 4'd1;
      if (cnt_q == 4'd9) begin
        div_busy_q <= 1'b0;
        xm_q <= xr_n[3:0];
        c_q  <= {xquo_q[8:0], xb};
        ym_q <= yr_n[3:0];
        yd_q <= {yquo_q[8:0], yb};
      end
    end else if (push_o) begin
      x_q <= x_d; y_q <= y_d; c_q <= c_d; yd_q <= yd_d; xm_q <= xm_d; ym_q <= ym_d;
    end
  end

endmodule

// ===== rtl/core/bqld_fifo.sv =====
// Two-entry queue of classified pixels between front end and engine.
// Depends on bqld_pkg.
module bqld_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bqld_pkg::item_t item_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output bqld_pkg::item_t item_o
);
  import bqld_pkg::*;

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

// ===== rtl/core/bqld_mac.sv =====
// Shared biquad unit: one 18x24 multiplier, five products summed over
// cycles, then rounded and saturated to 24 bits. Depends on bqld_pkg.
module bqld_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bqld_pkg::coefs_t                  coefs_i,
  input  logic                              start_i,
  input  logic signed [bqld_pkg::HistW-1:0] in0_i,
  input  logic signed [bqld_pkg::HistW-1:0] in1_i,
  input  logic signed [bqld_pkg::HistW-1:0] in2_i,
  input  logic signed [bqld_pkg::HistW-1:0] out1_i,
  input  logic signed [bqld_pkg::HistW-1:0] out2_i,
  output logic                              done_o,
  output logic signed [bqld_pkg::HistW-1:0] res_o
);
  import bqld_pkg::*;

  logic signed [HistW-1:0] op_q [5];
  logic [2:0]              step_q;
  logic                    busy_q, done_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q, rnd;
  logic signed [CoefW-1:0] cf;
  logic signed [HistW-1:0] op;

  always_comb begin
    case (step_q)
      3'd0: begin cf = coefs_i.b0; op = op_q[0]; end
      3'd1: begin cf = coefs_i.b1; op = op_q[1]; end
      3'd2: begin cf = coefs_i.b2; op = op_q[2]; end
      3'd3: begin cf = coefs_i.a1; op = op_q[3]; end
      default: begin cf = coefs_i.a2; op = op_q[4]; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q[0] <= in0_i; op_q[1] <= in1_i; op_q[2] <= in2_i;
      op_q[3] <= out1_i; op_q[4] <= out2_i;
    end
    prod_q <= ProdW'(cf * op);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
        acc_q  <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        // feedback terms are subtracted
        if (step_q >= 3'd4) acc_q <= acc_q - AccW'(prod_q);
        else if (step_q >= 3'd1) acc_q <= acc_q + AccW'(prod_q);
        if (step_q == 3'd5) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rnd = (acc_q + AccW'(1 << (FracBits - 1))) >>> FracBits;
    if (rnd > AccW'(8388607)) res_o = 24'sh7FFFFF;
    else if (rnd < -AccW'(8388608)) res_o = 24'sh800000;
    else res_o = rnd[HistW-1:0];
  end

  assign done_o = done_q;

endmodule

// ===== rtl/core/bqld_back.sv =====
// Filter engine: row biquad, per-column biquad with history in RAM, and the
// output register. Depends on bqld_pkg, bqld_out_if, bqld_mac, bqld_ram.
module bqld_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bqld_pkg::coefs_t      coefs_i,
  input  logic                  q_valid_i,
  input  bqld_pkg::item_t       item_i,
  output logic                  pop_o,
  output bqld_pkg::back_stat_t  stat_o,
  bqld_out_if.source            out_o
);
  import bqld_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_ROW  = 3'd3;
  localparam logic [2:0] S_COL  = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;

  logic [2:0]              state_q, state_d;
  item_t                   cur_q;
  logic [ColAw-1:0]        clr_q;
  logic signed [PixW-1:0]  rin0_q, rin1_q;
  logic signed [HistW-1:0] rout0_q, rout1_q, ci0_q, ci1_q, co0_q, co1_q;
  logic signed [HistW-1:0] row_q, colr_q, row_val;
  logic signed [HistW-1:0] m_in0, m_in1, m_in2, m_out1, m_out2, m_res;
  logic                    m_start, m_done, row_fin, out_free, out_load;
  logic                    ram_we;
  logic [ColAw-1:0]        ram_wa;
  logic [RamW-1:0]         ram_wd, ram_rd;
  logic signed [PixW-1:0]  pix_sat;

  bqld_mac u_mac (
    .clk_i, .rst_ni, .coefs_i, .start_i(m_start),
    .in0_i(m_in0), .in1_i(m_in1), .in2_i(m_in2), .out1_i(m_out1), .out2_i(m_out2),
    .done_o(m_done), .res_o(m_res)
  );

  bqld_ram #(.WIDTH(RamW), .DEPTH(MaxWidth)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(item_i.col), .rdata_o(ram_rd)
  );

  assign stat_o.clr_busy = state_q == S_CLR;
  assign pop_o    = state_q == S_IDLE && q_valid_i;
  assign out_free = !out_o.valid || out_o.ready;
  assign row_fin  = (state_q == S_RD && !cur_q.row_en) || (state_q == S_ROW && m_done);
  assign row_val  = cur_q.row_en ? m_res : '0;
  assign out_load = state_q == S_WB && cur_q.emit && out_free;

  always_comb begin
    state_d = state_q;
    m_start = 1'b0;
    m_in0   = HistW'(cur_q.pix);
    m_in1   = HistW'(rin0_q);
    m_in2   = HistW'(rin1_q);
    m_out1  = rout0_q;
    m_out2  = rout1_q;
    ram_we  = 1'b0;
    ram_wa  = cur_q.col;
    ram_wd  = {row_q, ci0_q, colr_q, co0_q};
    if (row_fin) begin
      m_in0 = row_val;
      // column history is still on the RAM output while in the read state
      if (state_q == S_RD) begin
        {m_in1, m_in2, m_out1, m_out2} = ram_rd;
      end else begin
        m_in1 = ci0_q; m_in2 = ci1_q; m_out1 = co0_q; m_out2 = co1_q;
      end
    end
    unique case (state_q)
      S_CLR: begin
        ram_we = 1'b1;
        ram_wa = clr_q;
        ram_wd = '0;
        if (clr_q == ColAw'(MaxWidth - 1)) state_d = S_IDLE;
      end
      S_IDLE: if (q_valid_i) state_d = S_RD;
      S_RD: if (cur_q.row_en) begin
        m_start = 1'b1;
        state_d = S_ROW;
      end
      S_ROW, S_COL: ;
      S_WB: begin
        ram_we = 1'b1;
        if (!cur_q.emit || out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (row_fin) begin
      if (!cur_q.col_en) state_d = S_IDLE;
      else if (cur_q.colf_en) begin
        m_start = 1'b1;
        state_d = S_COL;
      end else state_d = S_WB;
    end
    if (state_q == S_COL && m_done) state_d = S_WB;
  end

  always_comb begin
    if (colr_q > 24'sd32767) pix_sat = 16'sh7FFF;
    else if (colr_q < -24'sd32768) pix_sat = 16'sh8000;
    else pix_sat = colr_q[PixW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= item_i;
    if (state_q == S_RD) begin
      {ci0_q, ci1_q, co0_q, co1_q} <= ram_rd;
    end
    if (row_fin) begin
      row_q <= row_val;
      if (cur_q.col_en && !cur_q.colf_en) colr_q <= '0;
    end
    if (state_q == S_COL && m_done) colr_q <= m_res;
    if (out_load) begin
      out_o.pixel_out <= pix_sat;
      out_o.out_col   <= cur_q.col;
      out_o.out_row   <= cur_q.row;
      out_o.row_last  <= cur_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_o.valid <= 1'b0;
      rin0_q <= '0; rin1_q <= '0; rout0_q <= '0; rout1_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + ColAw'(1);
      if (out_load) out_o.valid <= 1'b1;
      else if (out_o.ready) out_o.valid <= 1'b0;
      if (row_fin) begin
        rin1_q  <= rin0_q;
        rin0_q  <= cur_q.pix;
        rout1_q <= rout0_q;
        rout0_q <= row_val;
      end
    end
  end

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_done |-> (state_q == S_ROW || state_q == S_COL))
    else $error("biquad unit finished outside a filter state");
  a_col_cls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COL |-> (cur_q.col_en && cur_q.colf_en))
    else $error("column filter run for a pixel without column work");
  a_wb_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB && !cur_q.emit) |=> state_q == S_IDLE)
    else $error("write-back without output did not return to idle");
  a_no_pop_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR |-> !pop_o)
    else $error("queue popped during history clear");

endmodule

// ===== rtl/core/biquad_lowpass_decimator_2d_core.sv =====
// Top level of the 2D biquad lowpass decimator: config registers, front end,
// pixel queue and filter engine. Depends on bqld_pkg and all bqld modules.
//
// Pixels enter in raster order; a biquad runs along each row and, at every
// D-th column, a second biquad runs down that column with its history held
// in a 1024-entry RAM. After reset the column history is cleared, and no
// pixel is accepted until that is done. Both filters share a single
// 18x24 multiplier that forms five products per biquad, so a pixel that
// runs the column filter takes longer than one that runs only the row
// filter, and the engine may also wait for the output to drain; a
// two-entry queue lets the input side run ahead. After a decimation factor
// write the front end rebuilds its phase counters, accepting no pixel meanwhile.
module biquad_lowpass_decimator_2d_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bqld_in_if.sink                        in_i,
  bqld_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [bqld_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bqld_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bqld_pkg::*;

  coefs_t            coefs_q;
  logic [DecimW-1:0] decim_q;
  logic [LineW-1:0]  width_q;
  back_stat_t        stat;
  item_t             f_item, q_item;
  logic              push, q_full, q_valid, pop, recalc;

  assign recalc = cfg_we_i && cfg_idx_i == CFG_DECIM;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefs_q <= '0;
      decim_q <= DecimW'(2);
      width_q <= LineW'(MaxWidth);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_B0:    coefs_q.b0 <= cfg_data_i;
        CFG_B1:    coefs_q.b1 <= cfg_data_i;
        CFG_B2:    coefs_q.b2 <= cfg_data_i;
        CFG_A1:    coefs_q.a1 <= cfg_data_i;
        CFG_A2:    coefs_q.a2 <= cfg_data_i;
        CFG_DECIM: decim_q <= cfg_data_i[DecimW-1:0];
        CFG_WIDTH: width_q <= cfg_data_i[LineW-1:0];
        default: ;
      endcase
    end
  end

  bqld_front u_front (
    .clk_i, .rst_ni, .in_i, .decim_i(decim_q), .width_i(width_q), .recalc_i(recalc),
    .stat_i(stat), .q_full_i(q_full), .push_o(push), .item_o(f_item)
  );

  bqld_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .item_i(f_item), .full_o(q_full),
    .valid_o(q_valid), .pop_i(pop), .item_o(q_item)
  );

  bqld_back u_back (
    .clk_i, .rst_ni, .coefs_i(coefs_q), .q_valid_i(q_valid), .item_i(q_item),
    .pop_o(pop), .stat_o(stat), .out_o
  );

endmodule
